[src/wmh_pkg.sv]
// ----------------------------------------------------------------------------
// wmh_pkg
// Shared constants, types and helpers of the windowed multi-histogram unit.
// ----------------------------------------------------------------------------
package wmh_pkg;

  localparam int T_BINS_DEF  = 1024;
  localparam int SA_BINS_DEF = 4096;
  localparam int X_BINS_DEF  = 2048;

  localparam int COUNT_W      = 32;
  localparam int DUR_W        = 16;
  localparam int VAL_W        = 32;
  localparam int EXT_W        = 16;
  localparam int IDX_W        = 12;
  localparam int MAXDUR_W     = 10;
  localparam int WIN_W        = 20;
  localparam int CFG_IDX_W    = 1;
  localparam int IN_TDATA_W   = 112;
  localparam int IN_TUSER_W   = 4;
  localparam int OUT_TDATA_W  = 168;
  localparam int OUT_TUSER_W  = 1;

  localparam logic [MAXDUR_W-1:0] MAX_DURATION_RST = 10'd1023;

  // commands
  localparam logic [1:0] CMD_RECORD = 2'd0;
  localparam logic [1:0] CMD_READ   = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  // histogram selectors
  localparam logic [1:0] SEL_DUR  = 2'd0;
  localparam logic [1:0] SEL_SIZE = 2'd1;
  localparam logic [1:0] SEL_AREA = 2'd2;
  localparam logic [1:0] SEL_EXT  = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DURATION = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_INDEX = 1'd1;

  typedef struct packed {
    logic rd_en;
    logic upd;
    logic clr;
  } bank_ctl_t;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    sat_inc = (v == '1) ? v : v + COUNT_W'(1);
  endfunction

endpackage

[src/wmh_bank.sv]
// ----------------------------------------------------------------------------
// wmh_bank
// One histogram memory: registered read, saturating increment written back,
// one-deep forwarding of the last write, and a clear write port.
// ----------------------------------------------------------------------------
module wmh_bank #(
  parameter int DEPTH = wmh_pkg::SA_BINS_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  wmh_pkg::bank_ctl_t           ctl,
  input  logic [AW-1:0]                rd_addr,
  input  logic [AW-1:0]                clr_addr,
  output logic [wmh_pkg::COUNT_W-1:0]  count
);

  logic [wmh_pkg::COUNT_W-1:0] mem [DEPTH];
  logic [wmh_pkg::COUNT_W-1:0] rd_data;
  logic [AW-1:0]               rd_addr_q;
  logic                        fwd_valid;
  logic [AW-1:0]               fwd_addr;
  logic [wmh_pkg::COUNT_W-1:0] fwd_data;
  logic [wmh_pkg::COUNT_W-1:0] inc;
  logic                        we;
  logic [AW-1:0]               wa;
  logic [wmh_pkg::COUNT_W-1:0] wd;

  assign count = (fwd_valid && fwd_addr == rd_addr_q) ? fwd_data : rd_data;
  assign inc   = wmh_pkg::sat_inc(count);
  assign we    = ctl.upd || ctl.clr;
  assign wa    = ctl.clr ? clr_addr : rd_addr_q;
  assign wd    = ctl.clr ? '0 : inc;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (ctl.rd_en) begin
      rd_data   <= mem[rd_addr];
      rd_addr_q <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (ctl.clr) begin
      fwd_valid <= 1'b0;
    end else if (ctl.upd) begin
      fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.upd) begin
      fwd_addr <= rd_addr_q;
      fwd_data <= inc;
    end
  end

endmodule

[src/windowed_multi_histogram_unit.sv]
// ----------------------------------------------------------------------------
// windowed_multi_histogram_unit
// Four histograms (duration, size, area, extent) fed by event records.
// ----------------------------------------------------------------------------
// Input items arrive on s_*: cmd in s_tuser selects record, read bin or clear.
// Every item gives one result item on m_* carrying the read bin, the record
// count, the four maxima and the sticky above-window flags of size and area.
// Configuration goes through cfg_*; cfg_ready is always high.
// Memory read on acceptance; increment, write-back and result on advance.
// Throughput: one item per cycle while results are taken and no clear pass
// runs, set by the read-modify-write of the four bin memories; a repeated bin
// is served from the forwarding register. A clear item, and reset, start a
// clear pass over max(T_BINS, SA_BINS, X_BINS) addresses (4096 by default)
// that zeroes all bins; s_tready stays low meanwhile.
// Reset also zeroes the counters, maxima and flags and loads the registers.
// When m_tready is low the result register holds, one more item is taken into
// the update stage, and then s_tready falls until the result is taken.
// ----------------------------------------------------------------------------
module windowed_multi_histogram_unit #(
  parameter int T_BINS  = wmh_pkg::T_BINS_DEF,
  parameter int SA_BINS = wmh_pkg::SA_BINS_DEF,
  parameter int X_BINS  = wmh_pkg::X_BINS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // duration, size_value, area_value, extent, bin_index, zero pad
  input  logic [wmh_pkg::IN_TDATA_W-1:0]    s_tdata,
  // cmd, hist_select
  input  logic [wmh_pkg::IN_TUSER_W-1:0]    s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // bin_count, record_count, max_duration_seen, max_size_seen, max_area_seen,
  // max_extent_seen, size_beyond, area_beyond, zero pad
  output logic [wmh_pkg::OUT_TDATA_W-1:0]   m_tdata,
  // bad_index
  output logic [wmh_pkg::OUT_TUSER_W-1:0]   m_tuser,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [wmh_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wmh_pkg::WIN_W-1:0]         cfg_data
);

  localparam int T_AW  = $clog2(T_BINS);
  localparam int SA_AW = $clog2(SA_BINS);
  localparam int X_AW  = $clog2(X_BINS);
  localparam int LW0   = wmh_pkg::WIN_W + SA_AW;
  localparam int LW    = ((LW0 > wmh_pkg::VAL_W) ? LW0 : wmh_pkg::VAL_W) + 1;
  localparam int MAXD0 = (T_BINS > X_BINS) ? T_BINS : X_BINS;
  localparam int MAXD  = (MAXD0 > SA_BINS) ? MAXD0 : SA_BINS;
  localparam int SW    = $clog2(MAXD);
  localparam int CW    = wmh_pkg::COUNT_W;

  // configuration
  logic [wmh_pkg::MAXDUR_W-1:0] max_duration;
  logic                         win_zero;
  logic [LW-1:0]                window_left;

  // input unpack
  logic [1:0]                   in_cmd;
  logic [1:0]                   in_sel;
  logic [wmh_pkg::DUR_W-1:0]    in_dur;
  logic [wmh_pkg::VAL_W-1:0]    in_size;
  logic [wmh_pkg::VAL_W-1:0]    in_area;
  logic [wmh_pkg::EXT_W-1:0]    in_ext;
  logic [wmh_pkg::IDX_W-1:0]    in_idx;

  logic        accept;
  logic        advance;
  logic        out_free;
  logic        rec_ok;
  logic [31:0] dur32;
  logic [31:0] ext32;
  logic [31:0] idx32;
  logic [LW-1:0] size_ext;
  logic [LW-1:0] area_ext;
  logic [LW-1:0] size_diff;
  logic [LW-1:0] area_diff;
  logic        size_ge;
  logic        area_ge;
  logic        size_in;
  logic        area_in;
  logic        is_read;
  logic        idx_bad;

  // update stage
  logic        p1_valid;
  logic [1:0]  p1_cmd;
  logic [1:0]  p1_sel;
  logic        p1_bad;
  logic        p1_zero;
  logic        p1_w0;
  logic        p1_dur_hit;
  logic        p1_ext_hit;
  logic        p1_size_hit;
  logic        p1_area_hit;
  logic        p1_size_over;
  logic        p1_area_over;
  logic [wmh_pkg::DUR_W-1:0] p1_dur;
  logic [wmh_pkg::VAL_W-1:0] p1_size;
  logic [wmh_pkg::VAL_W-1:0] p1_area;
  logic [wmh_pkg::EXT_W-1:0] p1_ext;

  // status
  logic [CW-1:0]              total;
  logic [wmh_pkg::DUR_W-1:0]  top_dur;
  logic [wmh_pkg::VAL_W-1:0]  top_size;
  logic [wmh_pkg::VAL_W-1:0]  top_area;
  logic [wmh_pkg::EXT_W-1:0]  top_ext;
  logic                       size_flag;
  logic                       area_flag;
  logic [CW-1:0]              total_next;
  logic [wmh_pkg::DUR_W-1:0]  top_dur_next;
  logic [wmh_pkg::VAL_W-1:0]  top_size_next;
  logic [wmh_pkg::VAL_W-1:0]  top_area_next;
  logic [wmh_pkg::EXT_W-1:0]  top_ext_next;
  logic                       size_flag_next;
  logic                       area_flag_next;
  logic [CW-1:0]              count_next;
  logic [CW-1:0]              bank_sel_count;

  // result register
  logic [CW-1:0]              o_count;
  logic [CW-1:0]              o_total;
  logic [wmh_pkg::DUR_W-1:0]  o_top_dur;
  logic [wmh_pkg::VAL_W-1:0]  o_top_size;
  logic [wmh_pkg::VAL_W-1:0]  o_top_area;
  logic [wmh_pkg::EXT_W-1:0]  o_top_ext;
  logic                       o_size_flag;
  logic                       o_area_flag;
  logic                       o_bad;

  // clear pass
  logic          clearing;
  logic [SW-1:0] clr_cnt;

  // banks
  wmh_pkg::bank_ctl_t dur_ctl;
  wmh_pkg::bank_ctl_t size_ctl;
  wmh_pkg::bank_ctl_t area_ctl;
  wmh_pkg::bank_ctl_t ext_ctl;
  logic [T_AW-1:0]    dur_addr;
  logic [SA_AW-1:0]   size_addr;
  logic [SA_AW-1:0]   area_addr;
  logic [X_AW-1:0]    ext_addr;
  logic [CW-1:0]      dur_count;
  logic [CW-1:0]      size_count;
  logic [CW-1:0]      area_count;
  logic [CW-1:0]      ext_count;

  assign in_cmd  = s_tuser[1:0];
  assign in_sel  = s_tuser[3:2];
  assign in_dur  = s_tdata[15:0];
  assign in_size = s_tdata[47:16];
  assign in_area = s_tdata[79:48];
  assign in_ext  = s_tdata[95:80];
  assign in_idx  = s_tdata[107:96];

  // configuration port
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_duration <= wmh_pkg::MAX_DURATION_RST;
      win_zero     <= 1'b1;
      window_left  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        wmh_pkg::REG_MAX_DURATION: begin
          max_duration <= cfg_data[wmh_pkg::MAXDUR_W-1:0];
        end
        wmh_pkg::REG_WINDOW_INDEX: begin
          win_zero    <= (cfg_data == '0);
          window_left <= LW'(cfg_data) * LW'(SA_BINS);
        end
        default: begin
        end
      endcase
    end
  end

  // handshake
  assign out_free = !m_tvalid || m_tready;
  assign advance  = p1_valid && out_free;
  assign s_tready = !clearing && !(p1_valid && p1_cmd == wmh_pkg::CMD_CLEAR)
                    && (!p1_valid || out_free);
  assign accept   = s_tvalid && s_tready;

  // decode
  assign dur32  = 32'(in_dur);
  assign ext32  = 32'(in_ext);
  assign idx32  = 32'(in_idx);
  assign rec_ok = (in_cmd == wmh_pkg::CMD_RECORD) && (in_dur != '0)
                  && (in_dur <= wmh_pkg::DUR_W'(max_duration));

  assign size_ext  = LW'(in_size);
  assign area_ext  = LW'(in_area);
  assign size_diff = size_ext - window_left;
  assign area_diff = area_ext - window_left;
  assign size_ge   = size_ext >= window_left;
  assign area_ge   = area_ext >= window_left;
  assign size_in   = size_ge && (size_diff < LW'(SA_BINS));
  assign area_in   = area_ge && (area_diff < LW'(SA_BINS));

  assign is_read = (in_cmd == wmh_pkg::CMD_READ);

  always_comb begin
    case (in_sel)
      wmh_pkg::SEL_DUR:  idx_bad = idx32 >= 32'(T_BINS);
      wmh_pkg::SEL_SIZE: idx_bad = idx32 >= 32'(SA_BINS);
      wmh_pkg::SEL_AREA: idx_bad = idx32 >= 32'(SA_BINS);
      wmh_pkg::SEL_EXT:  idx_bad = idx32 >= 32'(X_BINS);
      default:           idx_bad = 1'b1;
    endcase
  end

  assign dur_addr  = is_read ? idx32[T_AW-1:0]  : dur32[T_AW-1:0];
  assign ext_addr  = is_read ? idx32[X_AW-1:0]  : ext32[X_AW-1:0];
  assign size_addr = is_read ? idx32[SA_AW-1:0] : size_diff[SA_AW-1:0];
  assign area_addr = is_read ? idx32[SA_AW-1:0] : area_diff[SA_AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (accept) begin
      p1_valid <= 1'b1;
    end else if (advance) begin
      p1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1_cmd       <= in_cmd;
      p1_sel       <= in_sel;
      p1_bad       <= is_read && idx_bad;
      p1_zero      <= is_read && (in_idx == '0)
                      && (in_sel == wmh_pkg::SEL_DUR || in_sel == wmh_pkg::SEL_EXT
                          || win_zero);
      p1_w0        <= rec_ok && win_zero;
      p1_dur_hit   <= rec_ok && win_zero && (dur32 < 32'(T_BINS));
      p1_ext_hit   <= rec_ok && win_zero && (ext32 < 32'(X_BINS));
      p1_size_hit  <= rec_ok && size_in;
      p1_area_hit  <= rec_ok && area_in;
      p1_size_over <= rec_ok && size_ge && !size_in;
      p1_area_over <= rec_ok && area_ge && !area_in;
      p1_dur       <= in_dur;
      p1_size      <= in_size;
      p1_area      <= in_area;
      p1_ext       <= in_ext;
    end
  end

  // update stage
  always_comb begin
    case (p1_sel)
      wmh_pkg::SEL_DUR:  bank_sel_count = dur_count;
      wmh_pkg::SEL_SIZE: bank_sel_count = size_count;
      wmh_pkg::SEL_AREA: bank_sel_count = area_count;
      wmh_pkg::SEL_EXT:  bank_sel_count = ext_count;
      default:           bank_sel_count = '0;
    endcase
  end

  always_comb begin
    total_next     = total;
    top_dur_next   = top_dur;
    top_size_next  = top_size;
    top_area_next  = top_area;
    top_ext_next   = top_ext;
    size_flag_next = size_flag || p1_size_over;
    area_flag_next = area_flag || p1_area_over;
    count_next     = '0;
    if (p1_w0) begin
      total_next = wmh_pkg::sat_inc(total);
      if (p1_dur > top_dur) top_dur_next = p1_dur;
      if (p1_size > top_size) top_size_next = p1_size;
      if (p1_area > top_area) top_area_next = p1_area;
      if (p1_ext > top_ext) top_ext_next = p1_ext;
    end
    if (p1_cmd == wmh_pkg::CMD_READ && !p1_bad) begin
      count_next = p1_zero ? total : bank_sel_count;
    end
    if (p1_cmd == wmh_pkg::CMD_CLEAR) begin
      total_next     = '0;
      top_dur_next   = '0;
      top_size_next  = '0;
      top_area_next  = '0;
      top_ext_next   = '0;
      size_flag_next = 1'b0;
      area_flag_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total     <= '0;
      top_dur   <= '0;
      top_size  <= '0;
      top_area  <= '0;
      top_ext   <= '0;
      size_flag <= 1'b0;
      area_flag <= 1'b0;
    end else if (advance) begin
      total     <= total_next;
      top_dur   <= top_dur_next;
      top_size  <= top_size_next;
      top_area  <= top_area_next;
      top_ext   <= top_ext_next;
      size_flag <= size_flag_next;
      area_flag <= area_flag_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      o_count     <= count_next;
      o_total     <= total_next;
      o_top_dur   <= top_dur_next;
      o_top_size  <= top_size_next;
      o_top_area  <= top_area_next;
      o_top_ext   <= top_ext_next;
      o_size_flag <= size_flag_next;
      o_area_flag <= area_flag_next;
      o_bad       <= p1_bad;
    end
  end

  assign m_tdata = {6'd0, o_area_flag, o_size_flag, o_top_ext, o_top_area, o_top_size,
                    o_top_dur, o_total, o_count};
  assign m_tuser = o_bad;

  // clear pass
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (advance && p1_cmd == wmh_pkg::CMD_CLEAR) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + SW'(1);
      if (clr_cnt == SW'(MAXD - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // bank control
  always_comb begin
    dur_ctl.rd_en  = accept;
    dur_ctl.upd    = advance && p1_dur_hit;
    dur_ctl.clr    = clearing && ({1'b0, clr_cnt} < (SW + 1)'(T_BINS));
    size_ctl.rd_en = accept;
    size_ctl.upd   = advance && p1_size_hit;
    size_ctl.clr   = clearing && ({1'b0, clr_cnt} < (SW + 1)'(SA_BINS));
    area_ctl.rd_en = accept;
    area_ctl.upd   = advance && p1_area_hit;
    area_ctl.clr   = clearing && ({1'b0, clr_cnt} < (SW + 1)'(SA_BINS));
    ext_ctl.rd_en  = accept;
    ext_ctl.upd    = advance && p1_ext_hit;
    ext_ctl.clr    = clearing && ({1'b0, clr_cnt} < (SW + 1)'(X_BINS));
  end

  wmh_bank #(.DEPTH(T_BINS)) u_dur_bank (
    .clk      (clk),
    .rst      (rst),
    .ctl      (dur_ctl),
    .rd_addr  (dur_addr),
    .clr_addr (clr_cnt[T_AW-1:0]),
    .count    (dur_count)
  );

  wmh_bank #(.DEPTH(SA_BINS)) u_size_bank (
    .clk      (clk),
    .rst      (rst),
    .ctl      (size_ctl),
    .rd_addr  (size_addr),
    .clr_addr (clr_cnt[SA_AW-1:0]),
    .count    (size_count)
  );

  wmh_bank #(.DEPTH(SA_BINS)) u_area_bank (
    .clk      (clk),
    .rst      (rst),
    .ctl      (area_ctl),
    .rd_addr  (area_addr),
    .clr_addr (clr_cnt[SA_AW-1:0]),
    .count    (area_count)
  );

  wmh_bank #(.DEPTH(X_BINS)) u_ext_bank (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ext_ctl),
    .rd_addr  (ext_addr),
    .clr_addr (clr_cnt[X_AW-1:0]),
    .count    (ext_count)
  );

endmodule

[src/wmh_checker.sv]
// ----------------------------------------------------------------------------
// wmh_checker
// Port-level checks of the windowed multi-histogram unit, bound to the top.
// ----------------------------------------------------------------------------
module wmh_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tvalid,
  input logic                              s_tready,
  input logic [wmh_pkg::IN_TDATA_W-1:0]    s_tdata,
  input logic [wmh_pkg::IN_TUSER_W-1:0]    s_tuser,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [wmh_pkg::OUT_TDATA_W-1:0]   m_tdata,
  input logic [wmh_pkg::OUT_TUSER_W-1:0]   m_tuser,
  input logic                              cfg_valid,
  input logic                              cfg_ready,
  input logic [wmh_pkg::CFG_IDX_W-1:0]     cfg_index,
  input logic [wmh_pkg::WIN_W-1:0]         cfg_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // clear pass follows reset
  a_reset_blocks: assert property (@(posedge clk)
    rst |=> !s_tready && !m_tvalid)
    else $error("input taken right after reset");

  // bad read reports a zero count
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[31:0] == '0)
    else $error("bad index with nonzero count");

  // clear item blocks the input
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser[1:0] == wmh_pkg::CMD_CLEAR |=> !s_tready)
    else $error("input taken behind a clear item");

  // configuration always taken
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind windowed_multi_histogram_unit wmh_checker u_wmh_checker (.*);

[tb/histogram_checker.sv]
// ----------------------------------------------------------------------------
// histogram_checker
// Watches the item, result and configuration channels of the windowed
// multi-histogram unit, keeps its own copy of the four histograms, counters,
// maxima and sticky flags, predicts one status item per accepted item and
// compares every result item field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module histogram_checker
  import wmh_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  input  logic                     s_tready,
  input  logic [IN_TDATA_W-1:0]    s_tdata,
  input  logic [IN_TUSER_W-1:0]    s_tuser,
  input  logic                     m_tvalid,
  input  logic                     m_tready,
  input  logic [OUT_TDATA_W-1:0]   m_tdata,
  input  logic [OUT_TUSER_W-1:0]   m_tuser,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [WIN_W-1:0]         cfg_data,
  output int                       errors,
  output int                       pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [DUR_W-1:0] dur;
    logic [VAL_W-1:0] sz;
    logic [VAL_W-1:0] ar;
    logic [EXT_W-1:0] ext;
    logic [1:0]       sel;
    logic [IDX_W-1:0] idx;
  } record_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] bin_count;
    logic [COUNT_W-1:0] rec_count;
    logic [DUR_W-1:0]   peak_dur;
    logic [VAL_W-1:0]   peak_size;
    logic [VAL_W-1:0]   peak_area;
    logic [EXT_W-1:0]   peak_ext;
    logic               size_above;
    logic               area_above;
    logic               bad;
  } status_item_t;

  logic [COUNT_W-1:0]  dur_hist [T_BINS_DEF];
  logic [COUNT_W-1:0]  win_hist [2][SA_BINS_DEF];   // 0 size, 1 area
  logic [COUNT_W-1:0]  ext_hist [X_BINS_DEF];
  logic [COUNT_W-1:0]  rec_total;
  logic [DUR_W-1:0]    peak_dur;
  logic [VAL_W-1:0]    peak_size;
  logic [VAL_W-1:0]    peak_area;
  logic [EXT_W-1:0]    peak_ext;
  logic                above_flag [2];
  logic [MAXDUR_W-1:0] lim_dur;
  logic [WIN_W-1:0]    win_idx;

  status_item_t status_q [$];

  function automatic logic [COUNT_W-1:0] bump(input logic [COUNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  task automatic wipe_hist();
    for (int i = 0; i < T_BINS_DEF; i++) dur_hist[i] = '0;
    for (int i = 0; i < SA_BINS_DEF; i++) begin
      win_hist[0][i] = '0;
      win_hist[1][i] = '0;
    end
    for (int i = 0; i < X_BINS_DEF; i++) ext_hist[i] = '0;
    rec_total = '0;
    peak_dur = '0;
    peak_size = '0;
    peak_area = '0;
    peak_ext = '0;
    above_flag[0] = 1'b0;
    above_flag[1] = 1'b0;
  endtask

  // values below the window are dropped, above it set the sticky flag
  task automatic bin_window(input int h, input logic [63:0] left, input logic [VAL_W-1:0] v);
    logic [63:0] off;
    if (64'(v) >= left) begin
      off = 64'(v) - left;
      if (off < 64'(SA_BINS_DEF))
        win_hist[h][off] = bump(win_hist[h][off]);
      else
        above_flag[h] = 1'b1;
    end
  endtask

  task automatic predict_status(input record_item_t it, output status_item_t st);
    logic [63:0]        left;
    logic [COUNT_W-1:0] cnt;
    logic               bad;
    logic               count_at_zero;
    int                 depth;
    cnt = '0;
    bad = 1'b0;
    case (it.cmd)
      CMD_RECORD: begin
        if (it.dur != 0 && it.dur <= DUR_W'(lim_dur)) begin
          left = 64'(win_idx) * 64'(SA_BINS_DEF);
          if (win_idx == 0) begin
            if (it.dur > peak_dur) peak_dur = it.dur;
            if (it.sz > peak_size) peak_size = it.sz;
            if (it.ar > peak_area) peak_area = it.ar;
            if (it.ext > peak_ext) peak_ext = it.ext;
            if (int'(it.dur) < T_BINS_DEF) dur_hist[it.dur] = bump(dur_hist[it.dur]);
            if (int'(it.ext) < X_BINS_DEF) ext_hist[it.ext] = bump(ext_hist[it.ext]);
            rec_total = bump(rec_total);
          end
          bin_window(0, left, it.sz);
          bin_window(1, left, it.ar);
        end
      end
      CMD_READ: begin
        case (it.sel)
          SEL_DUR: begin
            depth = T_BINS_DEF;
            count_at_zero = 1'b1;
          end
          SEL_SIZE, SEL_AREA: begin
            depth = SA_BINS_DEF;
            count_at_zero = (win_idx == 0);
          end
          default: begin
            depth = X_BINS_DEF;
            count_at_zero = 1'b1;
          end
        endcase
        if (int'(it.idx) >= depth)
          bad = 1'b1;
        else if (it.idx == 0 && count_at_zero)
          cnt = rec_total;
        else begin
          case (it.sel)
            SEL_DUR:  cnt = dur_hist[it.idx];
            SEL_SIZE: cnt = win_hist[0][it.idx];
            SEL_AREA: cnt = win_hist[1][it.idx];
            default:  cnt = ext_hist[it.idx];
          endcase
        end
      end
      CMD_CLEAR: wipe_hist();
      default: ;
    endcase
    st.bin_count  = cnt;
    st.rec_count  = rec_total;
    st.peak_dur   = peak_dur;
    st.peak_size  = peak_size;
    st.peak_area  = peak_area;
    st.peak_ext   = peak_ext;
    st.size_above = above_flag[0];
    st.area_above = above_flag[1];
    st.bad        = bad;
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    record_item_t it;
    status_item_t want;
    status_item_t got;
    if (rst) begin
      wipe_hist();
      lim_dur = MAX_DURATION_RST;
      win_idx = '0;
      status_q.delete();
      errors = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.bin_count  = m_tdata[31:0];
        got.rec_count  = m_tdata[63:32];
        got.peak_dur   = m_tdata[79:64];
        got.peak_size  = m_tdata[111:80];
        got.peak_area  = m_tdata[143:112];
        got.peak_ext   = m_tdata[159:144];
        got.size_above = m_tdata[160];
        got.area_above = m_tdata[161];
        got.bad        = m_tuser[0];
        if (status_q.size() == 0) begin
          $display("%0t: result item with nothing expected, actual %h/%h",
                   $time, m_tdata, m_tuser);
          errors++;
        end else begin
          want = status_q.pop_front();
          check_field("bin_count", want.bin_count, got.bin_count);
          check_field("record_count", want.rec_count, got.rec_count);
          check_field("max_duration_seen", 32'(want.peak_dur), 32'(got.peak_dur));
          check_field("max_size_seen", want.peak_size, got.peak_size);
          check_field("max_area_seen", want.peak_area, got.peak_area);
          check_field("max_extent_seen", 32'(want.peak_ext), 32'(got.peak_ext));
          check_field("size_beyond", 32'(want.size_above), 32'(got.size_above));
          check_field("area_beyond", 32'(want.area_above), 32'(got.area_above));
          check_field("bad_index", 32'(want.bad), 32'(got.bad));
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_MAX_DURATION)
          lim_dur = cfg_data[MAXDUR_W-1:0];
        else
          win_idx = cfg_data;
      end
      if (s_tvalid && s_tready) begin
        it.cmd = s_tuser[1:0];
        it.sel = s_tuser[3:2];
        it.dur = s_tdata[15:0];
        it.sz  = s_tdata[47:16];
        it.ar  = s_tdata[79:48];
        it.ext = s_tdata[95:80];
        it.idx = s_tdata[107:96];
        predict_status(it, want);
        status_q.push_back(want);
      end
    end
    pending = status_q.size();
  end

endmodule

[tb/windowed_multi_histogram_unit_test.sv]
// ----------------------------------------------------------------------------
// windowed_multi_histogram_unit_test
// Drives directed and random records, reads, clears and no-ops into the
// windowed multi-histogram unit over several register settings, with bursty
// input, a receiver that stalls on its own pattern and one long hold-off.
// The checker beside the block predicts and compares every result item.
// ----------------------------------------------------------------------------
module windowed_multi_histogram_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import wmh_pkg::*;

  localparam logic [1:0] CMD_NOP = 2'd3;
  localparam int PHASE_ITEMS = 60;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 500000;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic [IN_TUSER_W-1:0]  s_tuser;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [OUT_TUSER_W-1:0] m_tuser;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [WIN_W-1:0]       cfg_data;

  int          chk_errors;
  int          chk_pending;
  int          cycles;
  logic        hold_req;
  int          cur_lim;
  logic [19:0] cur_win;

  windowed_multi_histogram_unit DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  histogram_checker CHK (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .errors(chk_errors), .pending(chk_pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("windowed_multi_histogram_unit_test: FAIL");
      $finish;
    end
  end

  // receiver: random modes, plus one long hold-off on request
  initial begin
    int mode;
    int mode_left;
    logic hold_done;
    m_tready = 1'b0;
    mode = 0;
    mode_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        m_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      case (mode)
        0:       m_tready = 1'b1;
        1:       m_tready = 1'($urandom_range(0, 1));
        2:       m_tready = ($urandom_range(0, 3) != 0);
        default: m_tready = ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  task automatic push_item(input logic [1:0] cmd, input logic [1:0] sel,
                           input logic [IDX_W-1:0] idx, input logic [DUR_W-1:0] dur,
                           input logic [VAL_W-1:0] sz, input logic [VAL_W-1:0] ar,
                           input logic [EXT_W-1:0] ext);
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tdata  = {4'd0, idx, ext, ar, sz, dur};
    s_tuser  = {sel, cmd};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic idle(input int n);
    @(negedge clk);
    s_tvalid = 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (chk_pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WIN_W-1:0] val);
    drain();
    repeat (4) @(negedge clk);
    while (!s_tready) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    if (idx == REG_MAX_DURATION)
      cur_lim = int'(val[MAXDUR_W-1:0]);
    else
      cur_win = val;
  endtask

  task automatic record(input logic [DUR_W-1:0] dur, input logic [VAL_W-1:0] sz,
                        input logic [VAL_W-1:0] ar, input logic [EXT_W-1:0] ext);
    push_item(CMD_RECORD, 2'($urandom), 12'($urandom), dur, sz, ar, ext);
  endtask

  task automatic read_bin(input logic [1:0] sel, input logic [IDX_W-1:0] idx);
    push_item(CMD_READ, sel, idx, 16'($urandom), $urandom, $urandom, 16'($urandom));
  endtask

  function automatic logic [DUR_W-1:0] pick_dur();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return (cur_lim == 0) ? 16'd1 : 16'($urandom_range(1, cur_lim));
      4, 5:       return 16'($urandom_range(1, 4));
      6:          return 16'(cur_lim);
      7:          return 16'(cur_lim + 1);
      8:          return 16'd0;
      default:    return 16'($urandom);
    endcase
  endfunction

  function automatic logic [VAL_W-1:0] pick_value(input logic [63:0] left);
    logic [63:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2: v = left + $urandom_range(0, 15);
      3, 4:    v = left + $urandom_range(0, 4095);
      5:       v = left + 4095;
      6:       v = left + 4096 + $urandom_range(0, 255);
      7:       v = (left == 0) ? 64'($urandom_range(0, 15)) : left - 1 - $urandom_range(0, 255);
      8:       v = ($urandom_range(0, 1) != 0) ? 64'hFFFF_FFFF : 64'd0;
      default: v = 64'($urandom);
    endcase
    if (v > 64'hFFFF_FFFF) v = 64'($urandom);
    return v[31:0];
  endfunction

  function automatic logic [EXT_W-1:0] pick_ext();
    case ($urandom_range(0, 7))
      0, 1, 2: return 16'($urandom_range(0, 15));
      3, 4:    return 16'($urandom_range(0, 2047));
      5:       return 16'd2047;
      6:       return 16'($urandom_range(2048, 65535));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_item();
    logic [63:0]      left;
    logic [1:0]       sel;
    logic [IDX_W-1:0] idx;
    int               depth;
    int               r;
    left = 64'(cur_win) * 64'(SA_BINS_DEF);
    r = $urandom_range(0, 99);
    if (r < 58) begin
      record(pick_dur(), pick_value(left), pick_value(left), pick_ext());
    end else if (r < 90) begin
      sel = 2'($urandom);
      case (sel)
        SEL_DUR:            depth = T_BINS_DEF;
        SEL_SIZE, SEL_AREA: depth = SA_BINS_DEF;
        default:            depth = X_BINS_DEF;
      endcase
      case ($urandom_range(0, 9))
        0, 1:    idx = '0;
        2, 3, 4: idx = 12'($urandom_range(0, 15));
        5, 6:    idx = 12'($urandom);
        7:       idx = 12'(depth - 1);
        8:       idx = (depth < 4096) ? 12'(depth) : 12'd4095;
        default: idx = 12'($urandom_range(0, depth - 1));
      endcase
      read_bin(sel, idx);
    end else if (r < 92) begin
      push_item(CMD_CLEAR, 2'($urandom), 12'($urandom), 16'($urandom), $urandom, $urandom,
                16'($urandom));
    end else if (r < 96) begin
      push_item(CMD_NOP, 2'($urandom), 12'($urandom), 16'($urandom), $urandom, $urandom,
                16'($urandom));
    end else begin
      push_item(2'($urandom), 2'($urandom), 12'($urandom), 16'($urandom), $urandom, $urandom,
                16'($urandom));
    end
  endtask

  task automatic directed_items();
    read_bin(SEL_DUR, 12'd0);
    record(16'd0, 32'd5, 32'd5, 16'd5);
    record(16'd1, 32'd0, 32'd0, 16'd0);
    record(16'd1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    record(16'd1024, 32'd7, 32'd7, 16'd7);
    record(16'hFFFF, 32'd7, 32'd7, 16'd7);
    record(16'd1023, 32'd4095, 32'd4095, 16'd2047);
    record(16'd500, 32'd4096, 32'd1, 16'd2048);
    record(16'd1, 32'd0, 32'd0, 16'd0);
    record(16'd1, 32'd0, 32'd0, 16'd0);
    read_bin(SEL_DUR, 12'd0);
    read_bin(SEL_DUR, 12'd1);
    read_bin(SEL_DUR, 12'd1023);
    read_bin(SEL_DUR, 12'd1024);
    read_bin(SEL_SIZE, 12'd0);
    read_bin(SEL_SIZE, 12'd4095);
    read_bin(SEL_AREA, 12'd4095);
    read_bin(SEL_AREA, 12'd1);
    read_bin(SEL_EXT, 12'd2047);
    read_bin(SEL_EXT, 12'd2048);
    read_bin(SEL_EXT, 12'd4095);
    push_item(CMD_NOP, 2'd3, 12'hFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    push_item(CMD_CLEAR, 2'd0, 12'd0, 16'd0, 32'd0, 32'd0, 16'd0);
    read_bin(SEL_SIZE, 12'd4095);
    read_bin(SEL_DUR, 12'd1);
  endtask

  initial begin
    int n;
    int burst;
    logic [MAXDUR_W-1:0] lim;
    logic [WIN_W-1:0] win;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    hold_req = 1'b0;
    cur_lim = 1023;
    cur_win = '0;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    directed_items();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0:       begin lim = 10'd1023; win = '0; end
        1:       begin lim = 10'($urandom_range(2, 1022)); win = '0; end
        2:       begin lim = 10'd1; win = '0; end
        3:       begin lim = 10'($urandom_range(2, 1022)); win = 20'd1; end
        4:       begin lim = 10'd1023; win = 20'hFFFFF; end
        5:       begin lim = 10'($urandom); win = 20'($urandom_range(2, 1048574)); end
        6:       begin lim = 10'd0; win = '0; end
        default: begin lim = 10'd1023; win = '0; end
      endcase
      write_reg(REG_MAX_DURATION, {10'($urandom), lim});
      write_reg(REG_WINDOW_INDEX, win);
      n = 0;
      while (n < PHASE_ITEMS) begin
        burst = $urandom_range(1, 16);
        for (int k = 0; k < burst && n < PHASE_ITEMS; k++) begin
          random_item();
          n++;
          if (ph == 2 && n == 5) hold_req = 1'b1;
          if (ph == 4 && n == 30) drain();
        end
        if ($urandom_range(0, 3) != 0) idle($urandom_range(1, 6));
      end
    end

    drain();
    repeat (20) @(negedge clk);
    if (chk_errors == 0)
      $display("windowed_multi_histogram_unit_test: PASS");
    else
      $display("windowed_multi_histogram_unit_test: FAIL");
    $finish;
  end

endmodule
